[sv/bpd_pkg.sv]
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types, constants and helpers for the biosignal packet deframer.
// ----------------------------------------------------------------------------
package bpd_pkg;

   localparam int EEG_WORDS = 4;
   localparam int AUX_BYTES = 6;

   localparam logic [5:0] LAST_INDEX = 6'd32;
   localparam logic [5:0] MAX_INDEX  = 6'd33;
   localparam logic [5:0] EEG_FIRST  = 6'd2;
   localparam logic [5:0] EEG_LAST   = 6'd13;
   localparam logic [5:0] AUX_FIRST  = 6'd26;
   localparam logic [5:0] AUX_LAST   = 6'd31;

   localparam logic [7:0] START_CODE = 8'hA0;
   localparam logic [7:0] END_ACCEL  = 8'hC0;
   localparam logic [7:0] END_ANALOG = 8'hC1;
   localparam logic [7:0] END_LAST   = 8'hC6;

   typedef enum logic [1:0] {
      STATUS_GOOD   = 2'd0,
      STATUS_LENGTH = 2'd1,
      STATUS_START  = 2'd2,
      STATUS_END    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_RAW    = 2'd0,
      KIND_ACCEL  = 2'd1,
      KIND_ANALOG = 2'd2
   } aux_kind_type;

   typedef struct packed {
      logic                             at_end;
      logic                             start_seen;
      logic [7:0]                       sample;
      logic [EEG_WORDS-1:0][23:0]       eeg;
      logic [AUX_BYTES-1:0][7:0]        aux;
   } frame_type;

   function automatic logic [1:0] eeg_slot(input logic [5:0] idx);
      logic [1:0] slot;
      priority if (idx <= 6'd4) begin
         slot = 2'd0;
      end else if (idx <= 6'd7) begin
         slot = 2'd1;
      end else if (idx <= 6'd10) begin
         slot = 2'd2;
      end else begin
         slot = 2'd3;
      end
      return slot;
   endfunction

   function automatic logic [15:0] neg_sat16(input logic [15:0] w);
      logic [15:0] r;
      if (w == 16'h8000) begin
         r = 16'h7FFF;
      end else begin
         r = 16'h0000 - w;
      end
      return r;
   endfunction

endpackage

[sv/biosignal_packet_deframer_top.sv]
// ----------------------------------------------------------------------------
// biosignal_packet_deframer_top
// Takes a 33-byte biosignal datagram one byte per word, with a flag on the
// final byte, and returns one result word per datagram carrying a status
// (ok, wrong length, bad start, bad end), the sample number, four signed
// 24-bit EEG counts and three aux words, remapped as accelerometer axes on
// end byte 0xC0 and tagged as analog inputs on 0xC1. One byte is taken every
// cycle; the result appears in the cycle after its final byte, held in a single
// output register. Bytes keep flowing while that register waits, and only a
// final byte arriving while the previous result is still untaken is stalled.
// ----------------------------------------------------------------------------
module biosignal_packet_deframer_top
   import bpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_sample_number,
   output logic signed [23:0] rsp_eeg_one,
   output logic signed [23:0] rsp_eeg_two,
   output logic signed [23:0] rsp_eeg_three,
   output logic signed [23:0] rsp_eeg_four,
   output logic signed [15:0] rsp_aux_first,
   output logic signed [15:0] rsp_aux_second,
   output logic signed [15:0] rsp_aux_third,
   output logic [7:0]         rsp_end_marker,
   output logic [1:0]         rsp_aux_kind
);

   frame_type frame;
   logic      take;
   logic      load;

   assign req_ready = ~reset & (~req_last_byte | ~rsp_valid | rsp_ready);
   assign take      = req_valid & req_ready;
   assign load      = take & req_last_byte;

   bpd_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .frame     (frame)
   );

   bpd_result u_result (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .data_byte         (req_data_byte),
      .frame             (frame),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_sample_number (rsp_sample_number),
      .rsp_eeg_one       (rsp_eeg_one),
      .rsp_eeg_two       (rsp_eeg_two),
      .rsp_eeg_three     (rsp_eeg_three),
      .rsp_eeg_four      (rsp_eeg_four),
      .rsp_aux_first     (rsp_aux_first),
      .rsp_aux_second    (rsp_aux_second),
      .rsp_aux_third     (rsp_aux_third),
      .rsp_end_marker    (rsp_end_marker),
      .rsp_aux_kind      (rsp_aux_kind)
   );

endmodule

[sv/bpd_capture.sv]
// ----------------------------------------------------------------------------
// bpd_capture
// Byte position counter and field capture registers for one datagram.
// ----------------------------------------------------------------------------
module bpd_capture
   import bpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output frame_type  frame
);

   logic [5:0]                 byte_index_ff, byte_index_in;
   logic                       start_seen_ff, start_seen_in;
   logic [7:0]                 sample_ff, sample_in;
   logic [EEG_WORDS-1:0][23:0] eeg_ff, eeg_in;
   logic [AUX_BYTES-1:0][7:0]  aux_ff, aux_in;
   logic [1:0]                 eeg_sel;
   logic [2:0]                 aux_off;

   assign eeg_sel = eeg_slot(byte_index_ff);
   assign aux_off = 3'(byte_index_ff - AUX_FIRST);

   always_comb begin
      byte_index_in = byte_index_ff;
      start_seen_in = start_seen_ff;
      sample_in     = sample_ff;
      eeg_in        = eeg_ff;
      aux_in        = aux_ff;
      if (take) begin
         if (byte_index_ff == 6'd0) begin
            start_seen_in = (data_byte == START_CODE);
         end else if (byte_index_ff == 6'd1) begin
            sample_in = data_byte;
         end else if (byte_index_ff >= EEG_FIRST && byte_index_ff <= EEG_LAST) begin
            eeg_in[eeg_sel] = {eeg_ff[eeg_sel][15:0], data_byte};
         end else if (byte_index_ff >= AUX_FIRST && byte_index_ff <= AUX_LAST) begin
            aux_in[aux_off] = data_byte;
         end
         if (last_byte) begin
            byte_index_in = 6'd0;
            start_seen_in = 1'b0;
         end else if (byte_index_ff < MAX_INDEX) begin
            byte_index_in = byte_index_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= 6'd0;
         start_seen_ff <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         start_seen_ff <= start_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      eeg_ff    <= eeg_in;
      aux_ff    <= aux_in;
   end

   assign frame.at_end     = (byte_index_ff == LAST_INDEX);
   assign frame.start_seen = start_seen_ff;
   assign frame.sample     = sample_ff;
   assign frame.eeg        = eeg_ff;
   assign frame.aux        = aux_ff;

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff <= MAX_INDEX)
      else $error("byte index beyond saturation point");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      take && last_byte |=> byte_index_ff == 6'd0 && !start_seen_ff)
      else $error("datagram state not cleared after final byte");

endmodule

[sv/bpd_result.sv]
// ----------------------------------------------------------------------------
// bpd_result
// Status check, aux remapping and the result register.
// ----------------------------------------------------------------------------
module bpd_result
   import bpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic [7:0]         data_byte,
   input  frame_type          frame,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_sample_number,
   output logic signed [23:0] rsp_eeg_one,
   output logic signed [23:0] rsp_eeg_two,
   output logic signed [23:0] rsp_eeg_three,
   output logic signed [23:0] rsp_eeg_four,
   output logic signed [15:0] rsp_aux_first,
   output logic signed [15:0] rsp_aux_second,
   output logic signed [15:0] rsp_aux_third,
   output logic [7:0]         rsp_end_marker,
   output logic [1:0]         rsp_aux_kind
);

   logic                       valid_ff, valid_in;
   status_type                 status_ff, status_in;
   aux_kind_type               kind_ff, kind_in;
   logic [7:0]                 sample_ff, sample_in;
   logic [EEG_WORDS-1:0][23:0] eeg_ff, eeg_in;
   logic [15:0]                aux_a_ff, aux_a_in;
   logic [15:0]                aux_b_ff, aux_b_in;
   logic [15:0]                aux_c_ff, aux_c_in;
   logic [7:0]                 end_ff, end_in;
   logic [15:0]                word_lo, word_mid, word_hi;

   assign word_lo  = {frame.aux[0], frame.aux[1]};
   assign word_mid = {frame.aux[2], frame.aux[3]};
   assign word_hi  = {frame.aux[4], frame.aux[5]};

   always_comb begin
      priority if (!frame.at_end) begin
         status_in = STATUS_LENGTH;
      end else if (!frame.start_seen) begin
         status_in = STATUS_START;
      end else if (data_byte < END_ACCEL || data_byte > END_LAST) begin
         status_in = STATUS_END;
      end else begin
         status_in = STATUS_GOOD;
      end
   end

   always_comb begin
      sample_in = 8'd0;
      eeg_in    = '0;
      aux_a_in  = 16'd0;
      aux_b_in  = 16'd0;
      aux_c_in  = 16'd0;
      kind_in   = KIND_RAW;
      end_in    = data_byte;
      if (status_in == STATUS_GOOD) begin
         sample_in = frame.sample;
         eeg_in    = frame.eeg;
         if (data_byte == END_ACCEL) begin
            aux_a_in = word_mid;
            aux_b_in = word_lo;
            aux_c_in = neg_sat16(word_hi);
            kind_in  = KIND_ACCEL;
         end else begin
            aux_a_in = word_lo;
            aux_b_in = word_mid;
            aux_c_in = word_hi;
            kind_in  = (data_byte == END_ANALOG) ? KIND_ANALOG : KIND_RAW;
         end
      end
   end

   assign valid_in = load | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         sample_ff <= sample_in;
         eeg_ff    <= eeg_in;
         aux_a_ff  <= aux_a_in;
         aux_b_ff  <= aux_b_in;
         aux_c_ff  <= aux_c_in;
         end_ff    <= end_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_sample_number = sample_ff;
   assign rsp_eeg_one       = eeg_ff[0];
   assign rsp_eeg_two       = eeg_ff[1];
   assign rsp_eeg_three     = eeg_ff[2];
   assign rsp_eeg_four      = eeg_ff[3];
   assign rsp_aux_first     = aux_a_ff;
   assign rsp_aux_second    = aux_b_ff;
   assign rsp_aux_third     = aux_c_ff;
   assign rsp_end_marker    = end_ff;
   assign rsp_aux_kind      = kind_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   a_ok_end_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff == STATUS_GOOD |-> end_ff >= END_ACCEL && end_ff <= END_LAST)
      else $error("ok status with end byte out of range");

   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != STATUS_GOOD
         |-> kind_ff == KIND_RAW && sample_ff == 8'd0 && aux_c_ff == 16'd0)
      else $error("error result carries payload");

endmodule

[sim/biosignal_packet_deframer_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biosignal_packet_deframer_top_test
// Sends biosignal datagrams, well-formed and broken, of 33 bytes and of other
// lengths, one byte per word into the deframer, tracks the expected result of
// each datagram in a scoreboard and checks every result word field by field,
// under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module biosignal_packet_deframer_top_test;
   import bpd_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   typedef struct packed {
      status_type   status;
      logic [7:0]   sample_number;
      logic [23:0]  eeg_one;
      logic [23:0]  eeg_two;
      logic [23:0]  eeg_three;
      logic [23:0]  eeg_four;
      logic [15:0]  aux_first;
      logic [15:0]  aux_second;
      logic [15:0]  aux_third;
      logic [7:0]   end_marker;
      aux_kind_type aux_kind;
   } packet_result_type;

   class packet_checker;
      logic [5:0]        byte_index;
      bit                start_seen;
      logic [7:0]        sample_hold;
      logic [23:0]       eeg_words[4];
      logic [7:0]        aux_bytes[6];
      packet_result_type expected_packets[$];
      int                errors;

      function new();
         byte_index = '0;
         start_seen = 1'b0;
         sample_hold = '0;
         foreach (eeg_words[i]) eeg_words[i] = '0;
         foreach (aux_bytes[i]) aux_bytes[i] = '0;
         errors = 0;
      endfunction

      function logic [15:0] aux_word(int first);
         return {aux_bytes[first], aux_bytes[first+1]};
      endfunction

      function logic [15:0] negate_clamped(logic [15:0] w);
         if (w == 16'h8000) begin
            return 16'h7FFF;
         end
         return ~w + 16'd1;
      endfunction

      function void take_byte(logic [7:0] b, logic last);
         packet_result_type r;
         logic [5:0]        idx;
         int                slot;
         idx = byte_index;
         if (idx == 6'd0) begin
            start_seen = (b == START_CODE);
         end else if (idx == 6'd1) begin
            sample_hold = b;
         end else if (idx >= EEG_FIRST && idx <= EEG_LAST) begin
            slot = (int'(idx) - int'(EEG_FIRST)) / 3;
            eeg_words[slot] = {eeg_words[slot][15:0], b};
         end else if (idx >= AUX_FIRST && idx <= AUX_LAST) begin
            aux_bytes[idx - AUX_FIRST] = b;
         end
         if (byte_index < MAX_INDEX) begin
            byte_index = byte_index + 6'd1;
         end
         if (!last) begin
            return;
         end
         r = '0;
         if (idx != LAST_INDEX) begin
            r.status = STATUS_LENGTH;
         end else if (!start_seen) begin
            r.status = STATUS_START;
         end else if (b < END_ACCEL || b > END_LAST) begin
            r.status = STATUS_END;
         end else begin
            r.status = STATUS_GOOD;
         end
         r.end_marker = b;
         if (r.status == STATUS_GOOD) begin
            r.sample_number = sample_hold;
            r.eeg_one = eeg_words[0];
            r.eeg_two = eeg_words[1];
            r.eeg_three = eeg_words[2];
            r.eeg_four = eeg_words[3];
            if (b == END_ACCEL) begin
               r.aux_first = aux_word(2);
               r.aux_second = aux_word(0);
               r.aux_third = negate_clamped(aux_word(4));
               r.aux_kind = KIND_ACCEL;
            end else begin
               r.aux_first = aux_word(0);
               r.aux_second = aux_word(2);
               r.aux_third = aux_word(4);
               r.aux_kind = (b == END_ANALOG) ? KIND_ANALOG : KIND_RAW;
            end
         end
         expected_packets.push_back(r);
         byte_index = '0;
         start_seen = 1'b0;
      endfunction

      function void compare_field(string name, logic [23:0] want, logic [23:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_packet(packet_result_type got);
         packet_result_type want;
         if (expected_packets.size() == 0) begin
            errors++;
            $display("%0t: unexpected result word, actual status %0d end %0h",
                     $time, got.status, got.end_marker);
            return;
         end
         want = expected_packets.pop_front();
         compare_field("status", 24'(want.status), 24'(got.status));
         compare_field("sample_number", 24'(want.sample_number), 24'(got.sample_number));
         compare_field("eeg_one", want.eeg_one, got.eeg_one);
         compare_field("eeg_two", want.eeg_two, got.eeg_two);
         compare_field("eeg_three", want.eeg_three, got.eeg_three);
         compare_field("eeg_four", want.eeg_four, got.eeg_four);
         compare_field("aux_first", 24'(want.aux_first), 24'(got.aux_first));
         compare_field("aux_second", 24'(want.aux_second), 24'(got.aux_second));
         compare_field("aux_third", 24'(want.aux_third), 24'(got.aux_third));
         compare_field("end_marker", 24'(want.end_marker), 24'(got.end_marker));
         compare_field("aux_kind", 24'(want.aux_kind), 24'(got.aux_kind));
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_data_byte = 8'h00;
   logic               req_last_byte = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_sample_number;
   logic signed [23:0] rsp_eeg_one;
   logic signed [23:0] rsp_eeg_two;
   logic signed [23:0] rsp_eeg_three;
   logic signed [23:0] rsp_eeg_four;
   logic signed [15:0] rsp_aux_first;
   logic signed [15:0] rsp_aux_second;
   logic signed [15:0] rsp_aux_third;
   logic [7:0]         rsp_end_marker;
   logic [1:0]         rsp_aux_kind;

   int            sender_idle_pct = 0;
   int            receiver_stall_pct = 0;
   int            bytes_sent = 0;
   packet_checker chk;

   biosignal_packet_deframer_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_sample_number (rsp_sample_number),
      .rsp_eeg_one       (rsp_eeg_one),
      .rsp_eeg_two       (rsp_eeg_two),
      .rsp_eeg_three     (rsp_eeg_three),
      .rsp_eeg_four      (rsp_eeg_four),
      .rsp_aux_first     (rsp_aux_first),
      .rsp_aux_second    (rsp_aux_second),
      .rsp_aux_third     (rsp_aux_third),
      .rsp_end_marker    (rsp_end_marker),
      .rsp_aux_kind      (rsp_aux_kind)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      packet_result_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            chk.take_byte(req_data_byte, req_last_byte);
         end
         if (rsp_valid && rsp_ready) begin
            got.status = status_type'(rsp_status);
            got.sample_number = rsp_sample_number;
            got.eeg_one = rsp_eeg_one;
            got.eeg_two = rsp_eeg_two;
            got.eeg_three = rsp_eeg_three;
            got.eeg_four = rsp_eeg_four;
            got.aux_first = rsp_aux_first;
            got.aux_second = rsp_aux_second;
            got.aux_third = rsp_aux_third;
            got.end_marker = rsp_end_marker;
            got.aux_kind = aux_kind_type'(rsp_aux_kind);
            chk.check_packet(got);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input byte_queue_type f);
      foreach (f[i]) begin
         send_byte(f[i], i == f.size() - 1);
      end
   endtask

   // hold the sender until every pending result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chk.expected_packets.size() != 0) @(posedge clock);
   endtask

   function automatic byte_queue_type random_frame(int len);
      byte_queue_type f;
      for (int i = 0; i < len; i++) begin
         f.push_back(8'($urandom_range(255)));
      end
      return f;
   endfunction

   function automatic byte_queue_type make_packet(logic [7:0] end_code);
      byte_queue_type f;
      f = random_frame(int'(LAST_INDEX) + 1);
      f[0] = START_CODE;
      f[LAST_INDEX] = end_code;
      return f;
   endfunction

   function automatic byte_queue_type make_length(int len);
      byte_queue_type f;
      f = random_frame(len);
      f[0] = START_CODE;
      f[len-1] = END_ACCEL;
      return f;
   endfunction

   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      byte_queue_type f;
      int             pick;
      int             len;
      int             random_base;
      logic [7:0]     b;
      chk = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 27;
      receiver_stall_pct = 52;

      f = make_packet(END_ACCEL);
      f[2] = 8'h7F; f[3] = 8'hFF; f[4] = 8'hFF;
      f[5] = 8'h80; f[6] = 8'h00; f[7] = 8'h00;
      f[8] = 8'hFF; f[9] = 8'hFF; f[10] = 8'hFF;
      f[11] = 8'h00; f[12] = 8'h00; f[13] = 8'h00;
      f[26] = 8'h80; f[27] = 8'h00; f[28] = 8'h7F; f[29] = 8'hFF;
      f[30] = 8'h80; f[31] = 8'h00;
      send_frame(f);
      f = make_packet(END_ACCEL);
      f[30] = 8'h00; f[31] = 8'h00;
      send_frame(f);
      f = make_packet(END_ACCEL);
      f[30] = 8'h7F; f[31] = 8'hFF;
      send_frame(f);
      for (int c = int'(END_ANALOG); c <= int'(END_LAST); c++) begin
         send_frame(make_packet(8'(c)));
      end
      for (int i = 0; i < 4; i++) begin
         f = make_packet(END_ACCEL);
         f[LAST_INDEX] = (i == 0) ? 8'hBF : (i == 1) ? 8'hC7 : (i == 2) ? 8'h00 : 8'hFF;
         send_frame(f);
      end
      f = make_packet(END_ANALOG);
      f[0] = 8'h00;
      send_frame(f);
      f = make_packet(END_ANALOG);
      f[0] = 8'hFF;
      send_frame(f);
      f = make_packet(8'hC7);
      f[0] = 8'hA1;
      send_frame(f);
      for (int i = 0; i < 6; i++) begin
         len = (i == 0) ? 1 : (i == 1) ? 2 : (i == 2) ? 32 : (i == 3) ? 34 : (i == 4) ? 40 : 64;
         send_frame(make_length(len));
      end
      drain_results();

      random_base = bytes_sent;
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 52 : 0;
         receiver_stall_pct = (phase == 0) ? 52 : (phase == 1) ? 27 : 0;
         while (bytes_sent < random_base + (phase + 1) * 215) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
               f = make_packet(8'($urandom_range(int'(END_ACCEL), int'(END_LAST))));
            end else if (pick < 78) begin
               f = make_packet(8'($urandom_range(int'(END_ACCEL), int'(END_LAST))));
               do b = 8'($urandom_range(255)); while (b == START_CODE);
               f[0] = b;
            end else if (pick < 86) begin
               f = make_packet(END_ACCEL);
               do b = 8'($urandom_range(255)); while (b >= END_ACCEL && b <= END_LAST);
               f[LAST_INDEX] = b;
            end else begin
               do len = $urandom_range(1, 48); while (len == int'(LAST_INDEX) + 1);
               f = random_frame(len);
               if ($urandom_range(1)) begin
                  f[0] = START_CODE;
               end
            end
            send_frame(f);
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (chk.expected_packets.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  chk.expected_packets.size());
      end
      if (chk.errors == 0 && chk.expected_packets.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
